/* hw/rtl/gapf_pkg.sv */
// ----------------------------------------------------------------------------
// gapf_pkg: shared types and constants for the grid A* path finder
// Item structs, heap key layout, heap request/status structs, command codes.
// ----------------------------------------------------------------------------
`default_nettype none

package gapf_pkg;

  localparam int MAX_WIDTH  = 32;
  localparam int MAX_HEIGHT = 32;
  localparam int COORD_W    = 5;
  localparam int CELL_W     = 2 * COORD_W;          // storage index {y, x}
  localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
  localparam int COST_W     = 11;
  localparam int LEN_W      = 11;
  localparam int DIM_W      = 6;
  localparam logic [COST_W-1:0] COST_INF = '1;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_FIND  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // register indexes
  localparam logic REG_MAP_WIDTH  = 1'b0;
  localparam logic REG_MAP_HEIGHT = 1'b1;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic               cell_open;
    logic [COORD_W-1:0] goal_x;
    logic [COORD_W-1:0] goal_y;
    logic [9:0]         step_index;
  } in_item_t;

  typedef struct packed {
    logic               path_found;
    logic [LEN_W-1:0]   path_length;
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
  } out_item_t;

  // Open list key: ordering by {f, y, x} equals ordering by {f, y*w + x}.
  typedef struct packed {
    logic [COST_W-1:0]  f;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } heap_key_t;

  localparam int KEY_W = $bits(heap_key_t);

  typedef struct packed {
    logic      clear;
    logic      push;
    logic      pop;
    heap_key_t key;
  } heap_req_t;

  typedef struct packed {
    logic      busy;
    logic      empty;
    heap_key_t top;
  } heap_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/gapf_ram.sv */
// ----------------------------------------------------------------------------
// gapf_ram: generic simple dual-port RAM
// One write port, one read port, read data registered (old data on collision).
// ----------------------------------------------------------------------------
`default_nettype none

module gapf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* hw/rtl/gapf_heap.sv */
// ----------------------------------------------------------------------------
// gapf_heap: min-heap open list over one RAM
// Push sifts up, pop sifts down, moving a hole; a push onto a full heap drops.
// ----------------------------------------------------------------------------
`default_nettype none

module gapf_heap import gapf_pkg::*; #(
  parameter int DEPTH = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  input  heap_req_t  req,
  output heap_stat_t stat
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [2:0] H_IDLE  = 3'd0;
  localparam logic [2:0] H_UP    = 3'd1;
  localparam logic [2:0] H_UPC   = 3'd2;
  localparam logic [2:0] H_PTOP  = 3'd3;
  localparam logic [2:0] H_PLAST = 3'd4;
  localparam logic [2:0] H_DN    = 3'd5;
  localparam logic [2:0] H_DNL   = 3'd6;
  localparam logic [2:0] H_DNR   = 3'd7;

  logic [2:0]       st_r, st_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [AW-1:0]    i_r, i_nxt;
  logic [KEY_W-1:0] k_r, k_nxt;
  logic [KEY_W-1:0] cl_r, cl_nxt;
  logic [KEY_W-1:0] top_r, top_nxt;

  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [KEY_W-1:0] wdata, rdata;

  logic [AW-1:0]    par;
  logic [AW+1:0]    lch, rch, cnt_x;
  logic             l_in, r_in, l_min;
  logic [KEY_W-1:0] mv;

  gapf_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (we),
    .wr_addr (waddr),
    .wr_data (wdata),
    .rd_addr (raddr),
    .rd_data (rdata)
  );

  assign par   = (i_r - AW'(1)) >> 1;
  assign lch   = {1'b0, i_r, 1'b1};
  assign rch   = lch + (AW+2)'(1);
  assign cnt_x = (AW+2)'(cnt_r);
  assign l_in  = lch < cnt_x;
  assign r_in  = rch < cnt_x;
  assign l_min = cl_r < k_r;
  assign mv    = l_min ? cl_r : k_r;

  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r;
    i_nxt   = i_r;
    k_nxt   = k_r;
    cl_nxt  = cl_r;
    top_nxt = top_r;
    we      = 1'b0;
    waddr   = i_r;
    wdata   = k_r;
    raddr   = i_r;
    case (st_r)
      H_IDLE: begin
        if (req.clear) begin
          cnt_nxt = '0;
        end else if (req.push) begin
          if (cnt_r != CW'(DEPTH)) begin
            i_nxt   = cnt_r[AW-1:0];
            k_nxt   = req.key;
            cnt_nxt = cnt_r + CW'(1);
            st_nxt  = H_UP;
          end
        end else if (req.pop) begin
          raddr   = '0;
          cnt_nxt = cnt_r - CW'(1);
          st_nxt  = H_PTOP;
        end
      end
      H_UP: begin
        if (i_r == '0) begin
          we     = 1'b1;
          st_nxt = H_IDLE;
        end else begin
          raddr  = par;
          st_nxt = H_UPC;
        end
      end
      H_UPC: begin
        we = 1'b1;
        if (rdata <= k_r) begin
          st_nxt = H_IDLE;
        end else begin
          wdata  = rdata;
          i_nxt  = par;
          st_nxt = H_UP;
        end
      end
      H_PTOP: begin
        top_nxt = rdata;
        raddr   = cnt_r[AW-1:0];
        st_nxt  = H_PLAST;
      end
      H_PLAST: begin
        k_nxt  = rdata;
        i_nxt  = '0;
        st_nxt = H_DN;
      end
      H_DN: begin
        if (!l_in) begin
          we     = 1'b1;
          st_nxt = H_IDLE;
        end else begin
          raddr  = lch[AW-1:0];
          st_nxt = H_DNL;
        end
      end
      H_DNL: begin
        cl_nxt = rdata;
        if (r_in) begin
          raddr  = rch[AW-1:0];
          st_nxt = H_DNR;
        end else if (rdata < k_r) begin
          we     = 1'b1;
          wdata  = rdata;
          i_nxt  = lch[AW-1:0];
          st_nxt = H_DN;
        end else begin
          we     = 1'b1;
          st_nxt = H_IDLE;
        end
      end
      H_DNR: begin
        we = 1'b1;
        if (rdata < mv) begin
          wdata  = rdata;
          i_nxt  = rch[AW-1:0];
          st_nxt = H_DN;
        end else if (l_min) begin
          wdata  = cl_r;
          i_nxt  = lch[AW-1:0];
          st_nxt = H_DN;
        end else begin
          st_nxt = H_IDLE;
        end
      end
      default: st_nxt = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= H_IDLE;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
    i_r   <= i_nxt;
    k_r   <= k_nxt;
    cl_r  <= cl_nxt;
    top_r <= top_nxt;
  end

  assign stat.busy  = st_r != H_IDLE;
  assign stat.empty = cnt_r == '0;
  assign stat.top   = top_r;

endmodule

`default_nettype wire

/* hw/rtl/grid_astar_path_finder.sv */
// ----------------------------------------------------------------------------
// grid_astar_path_finder: A* search on a 4-neighbour walkability grid
// A search clears the node RAM over the w*h grid in use, then per expanded cell pops
//   the heap and checks up to 4 neighbours, pushing each improved one; on the goal
//   it walks the parents back twice, first to count the path, then to store it.
// One item in flight; the heap RAM port and node RAM port set the search time.
// Reset: synchronous; a sweep then blocks every walk map cell, no items taken.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_astar_path_finder import gapf_pkg::*; #(
  parameter int HEAP_DEPTH = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [DIM_W-1:0] cfg_data
);

  // sequencer states
  localparam logic [4:0] S_WIPE   = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_CHK_S  = 5'd2;
  localparam logic [4:0] S_CHK_G  = 5'd3;
  localparam logic [4:0] S_CLR    = 5'd4;
  localparam logic [4:0] S_INIT   = 5'd5;
  localparam logic [4:0] S_PUSHW  = 5'd6;
  localparam logic [4:0] S_POP    = 5'd7;
  localparam logic [4:0] S_POPW   = 5'd8;
  localparam logic [4:0] S_CUR    = 5'd9;
  localparam logic [4:0] S_NB     = 5'd10;
  localparam logic [4:0] S_NBCHK  = 5'd11;
  localparam logic [4:0] S_LEN    = 5'd12;
  localparam logic [4:0] S_LEN2   = 5'd13;
  localparam logic [4:0] S_WR     = 5'd14;
  localparam logic [4:0] S_WR2    = 5'd15;
  localparam logic [4:0] S_RDPATH = 5'd16;

  // neighbour order: +x, -x, +y, -y
  localparam logic [2:0] DIR_XP   = 3'd0;
  localparam logic [2:0] DIR_XM   = 3'd1;
  localparam logic [2:0] DIR_YP   = 3'd2;
  localparam logic [2:0] DIR_YM   = 3'd3;
  localparam logic [2:0] DIR_DONE = 3'd4;

  // node RAM word: closed flag, parent cell, cost so far
  typedef struct packed {
    logic              done;
    logic [CELL_W-1:0] parent;
    logic [COST_W-1:0] cost;
  } node_t;

  function automatic logic [COORD_W:0] manh(input logic [COORD_W-1:0] ax,
                                            input logic [COORD_W-1:0] ay,
                                            input logic [COORD_W-1:0] bx,
                                            input logic [COORD_W-1:0] by);
    logic [COORD_W-1:0] dx, dy;
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    return {1'b0, dx} + {1'b0, dy};
  endfunction

  logic [4:0]         st_r, st_nxt;
  logic [4:0]         ret_r, ret_nxt;
  logic [DIM_W-1:0]   wreg_r, hreg_r;
  logic [DIM_W-1:0]   wc_r, wc_nxt, hc_r, hc_nxt;
  logic [LEN_W-1:0]   n_r, n_nxt;
  logic [COORD_W-1:0] sx_r, sx_nxt, sy_r, sy_nxt, gx_r, gx_nxt, gy_r, gy_nxt;
  logic [COORD_W-1:0] cx_r, cx_nxt, cy_r, cy_nxt;     // clear / wipe sweep
  logic [COORD_W-1:0] curx_r, curx_nxt, cury_r, cury_nxt;
  logic [COORD_W-1:0] nx_r, nx_nxt, ny_r, ny_nxt;
  logic [2:0]         dir_r, dir_nxt;
  logic [COST_W-1:0]  g_r, g_nxt;
  logic [CELL_W-1:0]  idx_r, idx_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt, kk_r, kk_nxt;
  logic               found_r, found_nxt;
  logic [LEN_W-1:0]   slen_r, slen_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r, out_nxt;

  logic [DIM_W-1:0]   wcl, hcl;
  logic               in_acc;
  logic               emit;
  out_item_t          em;

  logic               walk_we, walk_wdata, walk_rd;
  logic [CELL_W-1:0]  walk_waddr, walk_raddr;
  logic               node_we;
  logic [CELL_W-1:0]  node_waddr, node_raddr;
  node_t              node_wdata, node_rd;
  logic               path_we;
  logic [CELL_W-1:0]  path_waddr, path_raddr, path_wdata, path_rd;

  heap_req_t          hreq;
  heap_stat_t         hstat;

  logic [COORD_W-1:0] nb_x, nb_y;
  logic               nb_ok;

  gapf_ram #(.WIDTH(1), .DEPTH(CELLS)) u_walk (
    .clk (clk), .wr_en (walk_we), .wr_addr (walk_waddr), .wr_data (walk_wdata),
    .rd_addr (walk_raddr), .rd_data (walk_rd)
  );

  gapf_ram #(.WIDTH($bits(node_t)), .DEPTH(CELLS)) u_node (
    .clk (clk), .wr_en (node_we), .wr_addr (node_waddr), .wr_data (node_wdata),
    .rd_addr (node_raddr), .rd_data (node_rd)
  );

  gapf_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_path (
    .clk (clk), .wr_en (path_we), .wr_addr (path_waddr), .wr_data (path_wdata),
    .rd_addr (path_raddr), .rd_data (path_rd)
  );

  gapf_heap #(.DEPTH(HEAP_DEPTH)) u_heap (
    .clk (clk), .rst_n (rst_n), .req (hreq), .stat (hstat)
  );

  // dimension clamp: 0 acts as 1, above the maximum acts as the maximum
  assign wcl = (wreg_r == '0) ? DIM_W'(1) :
               (wreg_r > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : wreg_r;
  assign hcl = (hreg_r == '0) ? DIM_W'(1) :
               (hreg_r > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : hreg_r;

  // one beat at a time; the output register must be free or draining
  assign in_stall  = !((st_r == S_IDLE) && (!out_valid_r || !out_stall));
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // neighbour of the expanded cell for the current direction
  always_comb begin
    nb_x  = curx_r;
    nb_y  = cury_r;
    nb_ok = 1'b0;
    case (dir_r)
      DIR_XP: begin
        nb_x  = curx_r + COORD_W'(1);
        nb_ok = ({1'b0, curx_r} + DIM_W'(1)) < wc_r;
      end
      DIR_XM: begin
        nb_x  = curx_r - COORD_W'(1);
        nb_ok = curx_r != '0;
      end
      DIR_YP: begin
        nb_y  = cury_r + COORD_W'(1);
        nb_ok = ({1'b0, cury_r} + DIM_W'(1)) < hc_r;
      end
      DIR_YM: begin
        nb_y  = cury_r - COORD_W'(1);
        nb_ok = cury_r != '0;
      end
      default: nb_ok = 1'b0;
    endcase
  end

  always_comb begin
    st_nxt    = st_r;
    ret_nxt   = ret_r;
    wc_nxt    = wc_r;
    hc_nxt    = hc_r;
    n_nxt     = n_r;
    sx_nxt    = sx_r;
    sy_nxt    = sy_r;
    gx_nxt    = gx_r;
    gy_nxt    = gy_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    curx_nxt  = curx_r;
    cury_nxt  = cury_r;
    nx_nxt    = nx_r;
    ny_nxt    = ny_r;
    dir_nxt   = dir_r;
    g_nxt     = g_r;
    idx_nxt   = idx_r;
    len_nxt   = len_r;
    kk_nxt    = kk_r;
    found_nxt = found_r;
    slen_nxt  = slen_r;

    emit           = 1'b0;
    em.path_found  = found_r;
    em.path_length = slen_r;
    em.point_x     = '0;
    em.point_y     = '0;

    walk_we    = 1'b0;
    walk_waddr = {in_data.cell_y, in_data.cell_x};
    walk_wdata = in_data.cell_open;
    walk_raddr = {in_data.cell_y, in_data.cell_x};
    node_we    = 1'b0;
    node_waddr = {cury_r, curx_r};
    node_wdata = node_rd;
    node_raddr = idx_r;
    path_we    = 1'b0;
    path_waddr = CELL_W'(kk_r - LEN_W'(1));
    path_wdata = idx_r;
    path_raddr = in_data.step_index;

    hreq.clear = 1'b0;
    hreq.push  = 1'b0;
    hreq.pop   = 1'b0;
    hreq.key   = '0;

    case (st_r)
      S_WIPE: begin
        // walk map comes up all blocked
        walk_we    = 1'b1;
        walk_waddr = {cy_r, cx_r};
        walk_wdata = 1'b0;
        {cy_nxt, cx_nxt} = {cy_r, cx_r} + CELL_W'(1);
        if (&{cy_r, cx_r}) begin
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          case (in_data.cmd)
            CMD_WRITE: begin
              walk_we = 1'b1;
              emit    = 1'b1;
            end
            CMD_FIND: begin
              found_nxt  = 1'b0;
              slen_nxt   = '0;
              hreq.clear = 1'b1;
              wc_nxt     = wcl;
              hc_nxt     = hcl;
              sx_nxt     = in_data.cell_x;
              sy_nxt     = in_data.cell_y;
              gx_nxt     = in_data.goal_x;
              gy_nxt     = in_data.goal_y;
              if (({1'b0, in_data.cell_x} >= wcl) || ({1'b0, in_data.cell_y} >= hcl) ||
                  ({1'b0, in_data.goal_x} >= wcl) || ({1'b0, in_data.goal_y} >= hcl)) begin
                emit           = 1'b1;
                em.path_found  = 1'b0;
                em.path_length = '0;
              end else begin
                st_nxt = S_CHK_S;   // start cell walk bit is being read
              end
            end
            CMD_READ: begin
              if ({1'b0, in_data.step_index} < slen_r) begin
                st_nxt = S_RDPATH;
              end else begin
                emit = 1'b1;
              end
            end
            default: emit = 1'b1;
          endcase
        end
      end
      S_CHK_S: begin
        walk_raddr = {gy_r, gx_r};
        if (!walk_rd) begin
          emit           = 1'b1;
          em.path_found  = 1'b0;
          em.path_length = '0;
          st_nxt         = S_IDLE;
        end else begin
          st_nxt = S_CHK_G;
        end
      end
      S_CHK_G: begin
        if (!walk_rd) begin
          emit           = 1'b1;
          em.path_found  = 1'b0;
          em.path_length = '0;
          st_nxt         = S_IDLE;
        end else begin
          n_nxt  = LEN_W'({5'd0, wc_r} * {5'd0, hc_r});
          cx_nxt = '0;
          cy_nxt = '0;
          st_nxt = S_CLR;
        end
      end
      S_CLR: begin
        // reload cost, parent and closed flag over the grid in use
        node_we           = 1'b1;
        node_waddr        = {cy_r, cx_r};
        node_wdata.done   = 1'b0;
        node_wdata.parent = '0;
        node_wdata.cost   = COST_INF;
        if (cx_r == COORD_W'(wc_r - DIM_W'(1))) begin
          cx_nxt = '0;
          cy_nxt = cy_r + COORD_W'(1);
          if (cy_r == COORD_W'(hc_r - DIM_W'(1))) begin
            st_nxt = S_INIT;
          end
        end else begin
          cx_nxt = cx_r + COORD_W'(1);
        end
      end
      S_INIT: begin
        node_we           = 1'b1;
        node_waddr        = {sy_r, sx_r};
        node_wdata.done   = 1'b0;
        node_wdata.parent = '0;
        node_wdata.cost   = '0;
        hreq.push         = 1'b1;
        hreq.key.f        = COST_W'(manh(sx_r, sy_r, gx_r, gy_r));
        hreq.key.y        = sy_r;
        hreq.key.x        = sx_r;
        ret_nxt           = S_POP;
        st_nxt            = S_PUSHW;
      end
      S_PUSHW: begin
        if (!hstat.busy) begin
          st_nxt = ret_r;
        end
      end
      S_POP: begin
        if (hstat.empty) begin
          emit           = 1'b1;
          em.path_found  = 1'b0;
          em.path_length = '0;
          st_nxt         = S_IDLE;
        end else begin
          hreq.pop = 1'b1;
          st_nxt   = S_POPW;
        end
      end
      S_POPW: begin
        node_raddr = {hstat.top.y, hstat.top.x};
        if (!hstat.busy) begin
          curx_nxt = hstat.top.x;
          cury_nxt = hstat.top.y;
          st_nxt   = S_CUR;
        end
      end
      S_CUR: begin
        if (node_rd.done) begin
          st_nxt = S_POP;     // stale entry
        end else begin
          node_we         = 1'b1;
          node_wdata.done = 1'b1;
          g_nxt           = node_rd.cost + COST_W'(1);
          if ((curx_r == gx_r) && (cury_r == gy_r)) begin
            len_nxt = LEN_W'(1);
            idx_nxt = {gy_r, gx_r};
            st_nxt  = S_LEN;
          end else begin
            dir_nxt = DIR_XP;
            st_nxt  = S_NB;
          end
        end
      end
      S_NB: begin
        walk_raddr = {nb_y, nb_x};
        node_raddr = {nb_y, nb_x};
        if (dir_r == DIR_DONE) begin
          st_nxt = S_POP;
        end else if (!nb_ok) begin
          dir_nxt = dir_r + 3'd1;
        end else begin
          nx_nxt = nb_x;
          ny_nxt = nb_y;
          st_nxt = S_NBCHK;
        end
      end
      S_NBCHK: begin
        dir_nxt = dir_r + 3'd1;
        if (walk_rd && !node_rd.done && (g_r < node_rd.cost)) begin
          node_we           = 1'b1;
          node_waddr        = {ny_r, nx_r};
          node_wdata.done   = 1'b0;
          node_wdata.parent = {cury_r, curx_r};
          node_wdata.cost   = g_r;
          hreq.push         = 1'b1;
          hreq.key.f        = g_r + COST_W'(manh(nx_r, ny_r, gx_r, gy_r));
          hreq.key.y        = ny_r;
          hreq.key.x        = nx_r;
          ret_nxt           = S_NB;
          st_nxt            = S_PUSHW;
        end else begin
          st_nxt = S_NB;
        end
      end
      S_LEN: begin
        // count cells back to the start, bounded by the grid size
        if ((idx_r == {sy_r, sx_r}) || (len_r >= n_r)) begin
          idx_nxt = {gy_r, gx_r};
          kk_nxt  = len_r;
          st_nxt  = S_WR;
        end else begin
          st_nxt = S_LEN2;
        end
      end
      S_LEN2: begin
        idx_nxt = node_rd.parent;
        len_nxt = len_r + LEN_W'(1);
        st_nxt  = S_LEN;
      end
      S_WR: begin
        // store path from the goal end back toward the start
        if (kk_r == '0) begin
          found_nxt      = 1'b1;
          slen_nxt       = len_r;
          emit           = 1'b1;
          em.path_found  = 1'b1;
          em.path_length = len_r;
          st_nxt         = S_IDLE;
        end else begin
          path_we = 1'b1;
          st_nxt  = S_WR2;
        end
      end
      S_WR2: begin
        idx_nxt = node_rd.parent;
        kk_nxt  = kk_r - LEN_W'(1);
        st_nxt  = S_WR;
      end
      S_RDPATH: begin
        emit       = 1'b1;
        em.point_x = path_rd[COORD_W-1:0];
        em.point_y = path_rd[CELL_W-1:COORD_W];
        st_nxt     = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase

    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_nxt       = em;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_WIPE;
      ret_r       <= S_POP;
      cx_r        <= '0;
      cy_r        <= '0;
      wreg_r      <= DIM_W'(MAX_WIDTH);
      hreg_r      <= DIM_W'(MAX_HEIGHT);
      found_r     <= 1'b0;
      slen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      ret_r       <= ret_nxt;
      cx_r        <= cx_nxt;
      cy_r        <= cy_nxt;
      found_r     <= found_nxt;
      slen_r      <= slen_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MAP_WIDTH:  wreg_r <= cfg_data;
          REG_MAP_HEIGHT: hreg_r <= cfg_data;
          default: ;
        endcase
      end
    end
    wc_r   <= wc_nxt;
    hc_r   <= hc_nxt;
    n_r    <= n_nxt;
    sx_r   <= sx_nxt;
    sy_r   <= sy_nxt;
    gx_r   <= gx_nxt;
    gy_r   <= gy_nxt;
    curx_r <= curx_nxt;
    cury_r <= cury_nxt;
    nx_r   <= nx_nxt;
    ny_r   <= ny_nxt;
    dir_r  <= dir_nxt;
    g_r    <= g_nxt;
    idx_r  <= idx_nxt;
    len_r  <= len_nxt;
    kk_r   <= kk_nxt;
    out_r  <= out_nxt;
  end

endmodule

`default_nettype wire

/* tb/sv/grid_astar_path_finder_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_astar_path_finder_test: self-checking bench for the grid A* finder
// Drives cell writes, searches and path reads under random idling on both
// sides. A local A* predictor (same heap order and tie break) computes the
// results of the random beats; a short table of directed beats, most with their own expected results, opens the run.
// ----------------------------------------------------------------------------
module grid_astar_path_finder_test;
  import gapf_pkg::*;

  localparam int HEAP_SLOTS = 4096;
  localparam int IDLE_LIMIT = 1000000;  // cycles with no beat on any port
  localparam int DRAIN_WAIT = 40;
  localparam logic [1:0] CMD_NONE = 2'd3;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  in_item_t in_data;
  out_item_t out_data;
  logic cfg_valid, cfg_ready, cfg_index;
  logic [DIM_W-1:0] cfg_data;

  grid_astar_path_finder dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor state: mirror of the block's map, registers and stored path.
  // Map and path cells are kept as y*32+x storage indexes.
  // --------------------------------------------------------------------------
  bit          walk_bit [CELLS];
  int          path_cell [CELLS];
  int          path_len, path_ok;
  logic [5:0]  width_reg, height_reg;
  int          g_cost [CELLS];
  int          came_from [CELLS];
  bit          closed [CELLS];
  longint unsigned open_list [HEAP_SLOTS];
  int          open_count;

  out_item_t   results_due [$];
  int          errors, beats_out, idle_cycles;

  function automatic int clamp_dim(logic [5:0] v);
    if (v == 0) return 1;
    return (v > 32) ? 32 : int'(v);
  endfunction

  function automatic int absdiff(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  task automatic open_push(longint unsigned key);
    int i, p;
    longint unsigned t;
    if (open_count >= HEAP_SLOTS) return;   // full list drops the push
    i = open_count;
    open_count++;
    open_list[i] = key;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (open_list[p] <= open_list[i]) break;
      t = open_list[p]; open_list[p] = open_list[i]; open_list[i] = t;
      i = p;
    end
  endtask

  task automatic open_pop(output longint unsigned top);
    int i, l, r, m;
    longint unsigned t;
    top = open_list[0];
    open_count--;
    open_list[0] = open_list[open_count];
    i = 0;
    forever begin
      l = 2 * i + 1;
      r = l + 1;
      m = i;
      if (l < open_count && open_list[l] < open_list[m]) m = l;
      if (r < open_count && open_list[r] < open_list[m]) m = r;
      if (m == i) break;
      t = open_list[m]; open_list[m] = open_list[i]; open_list[i] = t;
      i = m;
    end
  endtask

  // A* over the configured grid; cells indexed y*w+x inside the search
  task automatic find_route(int sx, int sy, int gx, int gy);
    int w, h, n, start, goal, cur, len, idx, cx, cy, nx, ny, ni, g, k;
    longint unsigned key;
    int dx[4] = '{1, -1, 0, 0};
    int dy[4] = '{0, 0, 1, -1};
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    n = w * h;
    path_ok = 0;
    path_len = 0;
    open_count = 0;
    if (sx >= w || sy >= h || gx >= w || gy >= h) return;
    if (!walk_bit[sy*32+sx] || !walk_bit[gy*32+gx]) return;
    for (int i = 0; i < n; i++) begin
      g_cost[i] = -1;
      came_from[i] = 0;
      closed[i] = 0;
    end
    start = sy * w + sx;
    goal = gy * w + gx;
    g_cost[start] = 0;
    open_push((longint'(absdiff(sx, gx) + absdiff(sy, gy)) << 24) | start);
    while (open_count > 0) begin
      open_pop(key);
      cur = int'(key & 64'hFFFFFF);
      if (cur >= n || closed[cur]) continue;
      closed[cur] = 1;
      if (cur == goal) begin
        len = 1;
        idx = goal;
        while (idx != start && len < n) begin
          idx = came_from[idx];
          len++;
        end
        idx = goal;
        for (k = len; k > 0; k--) begin
          path_cell[k-1] = (idx / w) * 32 + (idx % w);
          idx = came_from[idx];
        end
        path_len = len;
        path_ok = 1;
        return;
      end
      cx = cur % w;
      cy = cur / w;
      for (k = 0; k < 4; k++) begin
        nx = cx + dx[k];
        ny = cy + dy[k];
        if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
        if (!walk_bit[ny*32+nx]) continue;
        ni = ny * w + nx;
        if (closed[ni]) continue;
        g = g_cost[cur] + 1;
        if (g_cost[ni] < 0 || g < g_cost[ni]) begin
          came_from[ni] = cur;
          g_cost[ni] = g;
          open_push((longint'(g + absdiff(nx, gx) + absdiff(ny, gy)) << 24) | ni);
        end
      end
    end
  endtask

  // Applies one accepted beat to the predictor and returns its result
  task automatic predict_result(input in_item_t it, output out_item_t res);
    int s;
    res = '0;
    case (it.cmd)
      CMD_WRITE: walk_bit[it.cell_y*32 + it.cell_x] = it.cell_open;
      CMD_FIND:  find_route(it.cell_x, it.cell_y, it.goal_x, it.goal_y);
      CMD_READ: begin
        s = it.step_index;
        if (s < path_len) begin
          res.point_x = COORD_W'(path_cell[s] % 32);
          res.point_y = COORD_W'(path_cell[s] / 32);
        end
      end
      default: ;
    endcase
    res.path_found = path_ok[0];
    res.path_length = path_len[LEN_W-1:0];
  endtask

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // --------------------------------------------------------------------------
  // Sender: one beat per call, gap drawn after acceptance. With no gap the
  // next call keeps in_valid high and just swaps the payload.
  // --------------------------------------------------------------------------
  bit eager_send;

  task automatic send_beat(in_item_t it, bit typed, out_item_t typed_res);
    out_item_t res;
    int gap;
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_result(it, res);
    results_due.insert(results_due.size(), typed ? typed_res : res);
    @(negedge clk);
    gap = eager_send ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    while (results_due.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // register writes only with the block idle
  task automatic write_reg(logic idx, logic [5:0] val);
    in_valid <= 1'b0;
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_MAP_WIDTH) width_reg = val;
    else height_reg = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t mk(logic [1:0] c, int x, int y, bit op, int gx, int gy,
                                  int si);
    in_item_t it;
    it.cmd = c; it.cell_x = COORD_W'(x); it.cell_y = COORD_W'(y); it.cell_open = op;
    it.goal_x = COORD_W'(gx); it.goal_y = COORD_W'(gy); it.step_index = 10'(si);
    return it;
  endfunction

  function automatic out_item_t rs(bit f, int l, int x, int y);
    out_item_t r;
    r.path_found = f; r.path_length = LEN_W'(l);
    r.point_x = COORD_W'(x); r.point_y = COORD_W'(y);
    return r;
  endfunction

  typedef struct {
    bit        reg_write;   // row writes a register instead of sending a beat
    logic      reg_sel;
    logic [5:0] reg_val;
    in_item_t  beat;
    bit        typed;
    out_item_t res;
  } stim_row_t;

  stim_row_t directed [$];

  function automatic stim_row_t row(in_item_t it, bit typed, out_item_t r);
    stim_row_t s;
    s.reg_write = 0; s.reg_sel = REG_MAP_WIDTH; s.reg_val = '0;
    s.beat = it; s.typed = typed; s.res = r;
    return s;
  endfunction

  function automatic stim_row_t reg_row(logic sel, logic [5:0] v);
    stim_row_t s;
    s = row('0, 0, '0);
    s.reg_write = 1; s.reg_sel = sel; s.reg_val = v;
    return s;
  endfunction

  task automatic add_row(stim_row_t s);
    directed.insert(directed.size(), s);
  endtask

  task automatic build_directed();
    // 32x32 after reset, nothing walkable yet
    add_row(row(mk(CMD_READ, 0, 0, 0, 0, 0, 0), 1, rs(0, 0, 0, 0)));
    add_row(row(mk(CMD_FIND, 0, 0, 0, 0, 0, 0), 1, rs(0, 0, 0, 0)));
    add_row(row(mk(CMD_WRITE, 0, 0, 1, 0, 0, 0), 1, rs(0, 0, 0, 0)));
    add_row(row(mk(CMD_FIND, 0, 0, 0, 0, 0, 0), 1, rs(1, 1, 0, 0)));
    add_row(row(mk(CMD_READ, 0, 0, 0, 0, 0, 0), 1, rs(1, 1, 0, 0)));
    add_row(row(mk(CMD_READ, 0, 0, 0, 0, 0, 1), 1, rs(1, 1, 0, 0)));
    add_row(row(mk(CMD_NONE, 31, 31, 1, 31, 31, 1023), 1, rs(1, 1, 0, 0)));
    add_row(row(mk(CMD_WRITE, 31, 31, 1, 0, 0, 0), 1, rs(1, 1, 0, 0)));
    // isolated goal: no route
    add_row(row(mk(CMD_FIND, 0, 0, 0, 31, 31, 0), 1, rs(0, 0, 0, 0)));
    // blocked start
    add_row(row(mk(CMD_FIND, 5, 5, 0, 0, 0, 0), 1, rs(0, 0, 0, 0)));
    // one row of four cells
    add_row(reg_row(REG_MAP_WIDTH, 6'd4));
    add_row(reg_row(REG_MAP_HEIGHT, 6'd1));
    for (int x = 1; x < 4; x++)
      add_row(row(mk(CMD_WRITE, x, 0, 1, 0, 0, 0), 1, rs(0, 0, 0, 0)));
    add_row(row(mk(CMD_FIND, 0, 0, 0, 3, 0, 0), 1, rs(1, 4, 0, 0)));
    add_row(row(mk(CMD_READ, 0, 0, 0, 0, 0, 3), 1, rs(1, 4, 3, 0)));
    add_row(row(mk(CMD_READ, 0, 0, 0, 0, 0, 2), 0, '0));
    add_row(row(mk(CMD_READ, 0, 0, 0, 0, 0, 1023), 1, rs(1, 4, 0, 0)));
    // register change keeps the stored cells
    add_row(reg_row(REG_MAP_WIDTH, 6'd0));
    add_row(row(mk(CMD_READ, 0, 0, 0, 0, 0, 3), 1, rs(1, 4, 3, 0)));
    add_row(reg_row(REG_MAP_WIDTH, 6'd4));
    // goal outside the rows in use
    add_row(row(mk(CMD_FIND, 0, 0, 0, 0, 1, 0), 1, rs(0, 0, 0, 0)));
    add_row(row(mk(CMD_WRITE, 31, 31, 0, 0, 0, 0), 1, rs(0, 0, 0, 0)));
    add_row(row(mk(CMD_FIND, 3, 0, 0, 1, 0, 0), 0, '0));
  endtask

  // random beat mostly inside the w x h grid in use
  function automatic in_item_t random_beat();
    int w, h, pick;
    in_item_t it;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    it = mk(CMD_WRITE, $urandom_range(0, w-1), $urandom_range(0, h-1),
            $urandom_range(0, 3) != 0, $urandom_range(0, w-1), $urandom_range(0, h-1),
            $urandom_range(0, 2 * w * h));
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      it.cell_x = COORD_W'($urandom); it.cell_y = COORD_W'($urandom);
      it.goal_x = COORD_W'($urandom); it.goal_y = COORD_W'($urandom);
      it.step_index = 10'($urandom);
    end
    pick = $urandom_range(0, 99);
    if (pick < 45) it.cmd = CMD_WRITE;
    else if (pick < 70) it.cmd = CMD_FIND;
    else if (pick < 97) it.cmd = CMD_READ;
    else it.cmd = CMD_NONE;
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  logic [5:0] phase_w [8] = '{6'd5, 6'd0, 6'd8, 6'd63, 6'd3, 6'd6, 6'd2, 6'd32};
  logic [5:0] phase_h [8] = '{6'd4, 6'd7, 6'd8, 6'd2, 6'd45, 6'd6, 6'd2, 6'd32};

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0; in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0; cfg_index = REG_MAP_WIDTH; cfg_data = '0;
    errors = 0; beats_out = 0; idle_cycles = 0; eager_send = 0;
    width_reg = 6'd32; height_reg = 6'd32;
    path_len = 0; path_ok = 0; open_count = 0;
    foreach (walk_bit[i]) walk_bit[i] = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    build_directed();
    foreach (directed[i]) begin
      if (directed[i].reg_write) write_reg(directed[i].reg_sel, directed[i].reg_val);
      else send_beat(directed[i].beat, directed[i].typed, directed[i].res);
    end

    for (int p = 0; p < 8; p++) begin
      write_reg(REG_MAP_WIDTH, phase_w[p]);
      write_reg(REG_MAP_HEIGHT, phase_h[p]);
      eager_send = (p % 3 == 1);        // back-to-back stretches
      // first open each of the first 12 cells with a 3 in 4 chance (not in the last phase)
      for (int y = 0; y < clamp_dim(height_reg) && p != 7; y++)
        for (int x = 0; x < clamp_dim(width_reg); x++)
          if ($urandom_range(0, 3) != 0 && x + y * clamp_dim(width_reg) < 12)
            send_beat(mk(CMD_WRITE, x, y, 1, 0, 0, 0), 0, '0);
      for (int k = 0; k < 9; k++) send_beat(random_beat(), 0, '0);
      in_valid <= 1'b0;
      drain_results();   // sender waits for every result before the next phase
    end
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall per beat, runs with no stall, one long hold-off
  // that backs the block up into its input.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int n;
    bit held;
    held = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      n = ((beats_out / 16) % 3 != 0) ? $urandom_range(0, 19) : 0;
      if (beats_out >= 40 && !held) begin
        held = 1;
        n = 300;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      beats_out <= beats_out + 1;
      if (results_due.size() == 0) begin
        report_mismatch("unexpected result beat", 1, 0);
      end else begin
        want = results_due.pop_front();
        if (out_data.path_found !== want.path_found)
          report_mismatch("path_found", out_data.path_found, want.path_found);
        if (out_data.path_length !== want.path_length)
          report_mismatch("path_length", out_data.path_length, want.path_length);
        if (out_data.point_x !== want.point_x)
          report_mismatch("point_x", out_data.point_x, want.point_x);
        if (out_data.point_y !== want.point_y)
          report_mismatch("point_y", out_data.point_y, want.point_y);
      end
    end
  end

  // watchdog: cycles without any beat on any port
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule
